@@ design/etp_pkg.sv @@
package etp_pkg;

    localparam int NUM_FUNCS_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 32;

    localparam int ID_W     = 8;
    localparam int TS_W     = 32;
    localparam int TOTAL_W  = 40;
    localparam int STATUS_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHARGE,
        ST_WRITE
    } state_t;

    // what the commit cycle does to stack, totals and output
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_CHARGE_PUSH,
        OP_POP,
        OP_OVERFLOW,
        OP_UNDERFLOW
    } op_t;

    typedef struct packed {
        logic clr_en;
        logic take;
        logic span_en;
        logic sum_en;
        logic commit;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic in_valid;
        logic is_end;
        logic id_bad;
        logic empty;
        logic full;
        logic out_busy;
    } stat_t;

endpackage

@@ design/etp_if.sv @@
interface etp_evt_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [etp_pkg::ID_W-1:0]   func_id;
    logic [etp_pkg::TS_W-1:0]   timestamp;

    modport source(output valid, req_type, func_id, timestamp, input ready);
    modport sink(input valid, req_type, func_id, timestamp, output ready);
endinterface

interface etp_chg_if;
    logic                         valid;
    logic                         ready;
    logic [etp_pkg::ID_W-1:0]     charged_id;
    logic [etp_pkg::TOTAL_W-1:0]  total_time;
    logic [etp_pkg::STATUS_W-1:0] status;

    modport source(output valid, charged_id, total_time, status, input ready);
    modport sink(input valid, charged_id, total_time, status, output ready);
endinterface

@@ design/etp_ctrl.sv @@
module etp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  etp_pkg::stat_t stat,
    output etp_pkg::cmd_t  cmd
);
    import etp_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            op_reg    <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cmd         = '0;
        cmd.op      = op_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (stat.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.in_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.span_en = 1'b1;
                if (!stat.is_end)
                begin
                    if (stat.id_bad)
                    begin
                        op_next    = OP_NONE;
                        state_next = ST_IDLE;
                    end
                    else if (stat.full)
                    begin
                        op_next    = OP_OVERFLOW;
                        state_next = ST_WRITE;
                    end
                    else if (stat.empty)
                    begin
                        op_next    = OP_PUSH;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        op_next    = OP_CHARGE_PUSH;
                        state_next = ST_CHARGE;
                    end
                end
                else if (stat.empty)
                begin
                    op_next    = OP_UNDERFLOW;
                    state_next = ST_WRITE;
                end
                else
                begin
                    op_next    = OP_POP;
                    state_next = ST_CHARGE;
                end
            end
            ST_CHARGE:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // a push alone emits nothing and never waits on the output
                if (op_reg == OP_PUSH || !stat.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ design/etp_datapath.sv @@
module etp_datapath #(
    parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = etp_pkg::TIME_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    etp_evt_if.sink        evt,
    etp_chg_if.source      chg,
    input  etp_pkg::cmd_t  cmd,
    output etp_pkg::stat_t stat
);
    import etp_pkg::*;

    localparam int FIDX_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SPAN_W = TIME_BITS + 1;
    localparam int SUM_W  = ((SPAN_W > TOTAL_W) ? SPAN_W : TOTAL_W) + 1;

    // stack, split so the resume time can be rewritten on its own
    logic [ID_W-1:0]      stk_id_mem  [STACK_DEPTH];
    logic [TIME_BITS-1:0] stk_res_mem [STACK_DEPTH];
    logic [TOTAL_W-1:0]   tot_mem     [NUM_FUNCS];

    logic                 req_reg;
    logic [ID_W-1:0]      fid_reg;
    logic [TIME_BITS-1:0] ts_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_W-1:0]      rd_id_reg;
    logic [TIME_BITS-1:0] rd_res_reg;
    logic [SPAN_W-1:0]    span_reg;
    logic [TOTAL_W-1:0]   tot_rd_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [FIDX_W-1:0]    clr_idx_reg;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [TOTAL_W-1:0]   out_total_reg;
    status_t              out_status_reg;

    logic                          accept;
    logic [TIME_BITS+TS_W-1:0]     ts_wide;
    logic [FIDX_W+ID_W-1:0]        id_wide;
    logic [FIDX_W-1:0]             tot_idx;
    logic [CNT_W-1:0]              cnt_m1, cnt_m2;
    logic [SPAN_W-1:0]             span_end, span_res;
    logic [SPAN_W-1:0]             span_next;
    logic [SUM_W-1:0]              sum;
    logic [TIME_BITS-1:0]          res_inc;
    logic                          emits;

    assign accept  = cmd.take && evt.valid;
    assign evt.ready = cmd.take;

    assign ts_wide = {{TIME_BITS{1'b0}}, evt.timestamp};
    assign id_wide = {{FIDX_W{1'b0}}, rd_id_reg};
    assign tot_idx = id_wide[FIDX_W-1:0];
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);

    // start: ts - resume, end: ts + 1 - resume, both clipped at zero
    assign span_end  = {1'b0, ts_reg} + SPAN_W'(req_reg);
    assign span_res  = {1'b0, rd_res_reg};
    assign span_next = (span_end > span_res) ? (span_end - span_res) : '0;

    assign sum = SUM_W'(tot_rd_reg) + SUM_W'(span_reg);

    assign res_inc = (ts_reg == {TIME_BITS{1'b1}}) ? ts_reg : ts_reg + TIME_BITS'(1);

    assign emits = (cmd.op == OP_CHARGE_PUSH) || (cmd.op == OP_POP)
                || (cmd.op == OP_OVERFLOW) || (cmd.op == OP_UNDERFLOW);

    assign stat.clr_done = (clr_idx_reg == FIDX_W'(NUM_FUNCS - 1));
    assign stat.in_valid = evt.valid;
    assign stat.is_end   = req_reg;
    assign stat.id_bad   = ({24'b0, fid_reg} >= NUM_FUNCS);
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stat.out_busy = out_valid_reg && !chg.ready;

    assign chg.valid      = out_valid_reg;
    assign chg.charged_id = out_id_reg;
    assign chg.total_time = out_total_reg;
    assign chg.status     = out_status_reg;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            case (cmd.op) inside
                OP_PUSH, OP_CHARGE_PUSH: count_next = count_reg + CNT_W'(1);
                OP_POP:                  count_next = cnt_m1;
                default:                 count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.clr_en && !stat.clr_done)
                clr_idx_reg <= clr_idx_reg + FIDX_W'(1);
            if (cmd.commit && emits)
                out_valid_reg <= 1'b1;
            else if (chg.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= evt.req_type;
            fid_reg <= evt.func_id;
            ts_reg  <= ts_wide[TIME_BITS-1:0];
        end
        if (cmd.span_en)
            span_reg <= span_next;
        if (cmd.sum_en)
            total_reg <= (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        if (cmd.commit && emits)
        begin
            case (cmd.op)
                OP_OVERFLOW:
                begin
                    out_id_reg     <= fid_reg;
                    out_total_reg  <= '0;
                    out_status_reg <= STAT_OVERFLOW;
                end
                OP_UNDERFLOW:
                begin
                    out_id_reg     <= '0;
                    out_total_reg  <= '0;
                    out_status_reg <= STAT_UNDERFLOW;
                end
                default:
                begin
                    out_id_reg     <= rd_id_reg;
                    out_total_reg  <= total_reg;
                    out_status_reg <= STAT_OK;
                end
            endcase
        end
    end

    // stack memories: top read on accept, push or resume rewrite on commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_id_reg  <= stk_id_mem[cnt_m1[SA_W-1:0]];
            rd_res_reg <= stk_res_mem[cnt_m1[SA_W-1:0]];
        end
        if (cmd.commit && (cmd.op == OP_PUSH || cmd.op == OP_CHARGE_PUSH))
        begin
            stk_id_mem[count_reg[SA_W-1:0]]  <= fid_reg;
            stk_res_mem[count_reg[SA_W-1:0]] <= ts_reg;
        end
        else if (cmd.commit && cmd.op == OP_POP && count_reg > CNT_W'(1))
        begin
            stk_res_mem[cnt_m2[SA_W-1:0]] <= res_inc;
        end
    end

    // totals memory: clearing sweep after reset, read-modify-write per charge
    always_ff @(posedge clk)
    begin
        if (cmd.span_en)
            tot_rd_reg <= tot_mem[tot_idx];
        if (cmd.clr_en)
            tot_mem[clr_idx_reg] <= '0;
        else if (cmd.commit && (cmd.op == OP_CHARGE_PUSH || cmd.op == OP_POP))
            tot_mem[tot_idx] <= total_reg;
    end

endmodule

@@ design/exclusive_time_profiler.sv @@
// Exclusive-time profiler for a stream of call trace transactions.
//
// evt (sink): one transaction per call event: req_type 0 = function start with
//   func_id, 1 = function end; timestamp is nondecreasing.
// chg (source): zero or one transaction per event: the charged function, its
//   new saturating 40-bit exclusive total and a status code (ok, stack
//   overflow on start, end on an empty stack).
//
// Timing: an event is taken in the idle cycle, then the stack top is read,
//   the span formed and the total read, the sum saturated, and the commit
//   cycle writes back the total, pushes or pops the stack and loads the output
//   register. The stack read, totals read and saturating add are registered.
//   A charging event passes every step; a push on an empty stack and an
//   overflow or underflow report skip the sum; an ignored start (id out of
//   range) ends after the read. The result is valid in the cycle after commit.
// Stall: the output register holds a result while chg.ready is low; the block
//   still accepts and works on the next event and waits only in its commit
//   cycle if that event also has a result to deliver.
// Reset: rst_n clears the stack count and starts a clearing pass over all
//   NUM_FUNCS entries of the totals memory, with evt.ready low throughout.
module exclusive_time_profiler #(
    parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF,
    parameter int TIME_BITS   = etp_pkg::TIME_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    etp_evt_if.sink    evt,
    etp_chg_if.source  chg
);
    import etp_pkg::*;

    // commands from the sequencer, status back from the datapath
    cmd_t  cmd;
    stat_t stat;

    etp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // stack memories, totals memory, span and saturating adder, output register
    etp_datapath #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .chg   (chg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
